// ===== hw/rtl/windowed_timing_stats_assert.svh =====
// ----------------------------------------------------------------------------
// Windowed timing statistics assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_TIMING_STATS_ASSERT_SVH
`define WINDOWED_TIMING_STATS_ASSERT_SVH

// same-cycle implication
`define WTS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WTS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/wts_pkg.sv =====
// ----------------------------------------------------------------------------
// Windowed timing statistics package
// Sizes, transaction payload types, sequencer states and shared-unit codes.
// ----------------------------------------------------------------------------
`default_nettype none

package wts_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int SAMPLE_BITS  = 24;

    localparam int FIELD_W   = 24;
    localparam int OUT_CNT_W = 7;

    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SQR_W  = 2 * SAMPLE_BITS;
    localparam int SQ_W   = 2 * SAMPLE_BITS + ADDR_W;
    localparam int ROOT_W = SAMPLE_BITS;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int UNIT_W = (CNT_W + 1 > ROOT_W + 2) ? CNT_W + 1 : ROOT_W + 2;
    localparam int STEP_W = $clog2(SQ_W + 1);

    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] sample_us;
    } wts_req_t;

    typedef struct packed {
        logic [FIELD_W-1:0]   average_us;
        logic [FIELD_W-1:0]   maximum_us;
        logic [FIELD_W-1:0]   jitter_rms_us;
        logic [OUT_CNT_W-1:0] stored_samples;
    } wts_rsp_t;

    typedef enum logic {
        MODE_DIV,
        MODE_SQRT
    } wts_mode_t;

    typedef struct packed {
        logic      start;
        wts_mode_t mode;
    } wts_unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } wts_unit_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM_RD,
        ST_SUM_DRAIN,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_DEV_RD,
        ST_DEV_DRAIN,
        ST_VAR_START,
        ST_VAR_WAIT,
        ST_ROOT_START,
        ST_ROOT_WAIT,
        ST_DONE
    } wts_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wts_store.sv =====
// ----------------------------------------------------------------------------
// Sample ring store
// One write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_store
    import wts_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [ADDR_W-1:0]      waddr,
    input  wire logic [SAMPLE_BITS-1:0] wdata,
    input  wire logic [ADDR_W-1:0]      raddr,
    output logic      [SAMPLE_BITS-1:0] rdata
);

    logic [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wts_divsqrt.sv =====
// ----------------------------------------------------------------------------
// Shared divide / square root unit
// Restoring division by the sample count, one quotient bit per cycle, or
// digit-by-digit integer square root, one root bit per cycle. Both modes
// share one compare-subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_divsqrt
    import wts_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire wts_unit_ctl_t   ctl,
    input  wire logic [SQ_W-1:0] operand,
    input  wire logic [CNT_W-1:0] divisor,
    output wts_unit_stat_t       stat,
    output logic [SQ_W-1:0]      quotient,
    output logic [ROOT_W-1:0]    root
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    wts_mode_t         mode_reg, mode_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SQ_W-1:0]   sh_reg, sh_next;
    logic [UNIT_W-1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  dvsr_reg, dvsr_next;

    logic [UNIT_W-1:0] trial_a;
    logic [UNIT_W-1:0] trial_b;
    logic [UNIT_W:0]   diff;
    logic              fit;
    logic              last;

    always_comb
    begin
        if (mode_reg == MODE_DIV)
        begin
            trial_a = UNIT_W'({rem_reg[CNT_W-1:0], sh_reg[SQ_W-1]});
            trial_b = UNIT_W'(dvsr_reg);
            last    = (step_reg == STEP_W'(SQ_W - 1));
        end
        else
        begin
            trial_a = {rem_reg[UNIT_W-3:0], sh_reg[RAD_W-1 -: 2]};
            trial_b = UNIT_W'({root_reg, 2'b01});
            last    = (step_reg == STEP_W'(ROOT_W - 1));
        end
        diff = {1'b0, trial_a} - {1'b0, trial_b};
        fit  = !diff[UNIT_W];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        step_next = step_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        dvsr_next = dvsr_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            mode_next = ctl.mode;
            step_next = '0;
            sh_next   = operand;
            rem_next  = '0;
            root_next = '0;
            dvsr_next = divisor;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + STEP_W'(1);
            if (mode_reg == MODE_DIV)
            begin
                rem_next = fit ? UNIT_W'(diff[CNT_W-1:0]) : UNIT_W'(trial_a[CNT_W-1:0]);
                sh_next  = {sh_reg[SQ_W-2:0], fit};
            end
            else
            begin
                rem_next  = fit ? diff[UNIT_W-1:0] : trial_a;
                root_next = {root_reg[ROOT_W-2:0], fit};
                sh_next   = sh_reg << 2;
            end
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= MODE_DIV;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mode_reg <= mode_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        dvsr_reg <= dvsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = sh_reg;
    assign root      = root_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/windowed_timing_stats.sv =====
// ----------------------------------------------------------------------------
// Windowed timing statistics monitor
// Records duration samples in a ring and answers queries with mean, peak
// since reset, sample count and jitter (isqrt of the mean squared deviation).
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_ready   wts_req_t (func, sample_us)
//   rsp       out         rsp_valid / rsp_ready   wts_rsp_t (four statistics)
//
// Record transaction: no response.
// Query: a sum pass and a deviation pass over the single store read port,
// each followed by the shared one-bit-per-cycle divide / square root unit.
// Empty store: both passes are skipped.
// Reset clears control state only; the store has no clearing pass.
// The response register holds a result until taken; records are accepted
// meanwhile, and a finished query waits for the register to free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "windowed_timing_stats_assert.svh"

module windowed_timing_stats
    import wts_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire wts_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output wts_rsp_t      rsp
);

    wts_state_t             state_reg, state_next;
    logic [ADDR_W-1:0]      slot_reg, slot_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [SAMPLE_BITS-1:0] peak_reg, peak_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   dv_reg, dv_next;
    logic                   dfv_reg, dfv_next;
    logic                   sqv_reg, sqv_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    logic [SQ_W-1:0]        acc_reg, acc_next;
    logic [SAMPLE_BITS-1:0] diff_reg, diff_next;
    logic [SQR_W-1:0]       sqr_reg, sqr_next;
    logic [SAMPLE_BITS-1:0] mean_reg, mean_next;
    logic [ROOT_W-1:0]      jit_reg, jit_next;
    wts_rsp_t               rsp_reg, rsp_next;

    logic                   accept;
    logic                   rec_we;
    logic                   query_go;
    logic                   rd_issue;
    logic                   sum_phase;
    logic                   rsp_load;
    logic                   last_idx;
    logic [SAMPLE_BITS-1:0] sample_sat;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [SQ_W-1:0]        operand;
    logic [SQ_W-1:0]        quotient;
    logic [ROOT_W-1:0]      root;
    wts_unit_ctl_t          unit_ctl;
    wts_unit_stat_t         unit_stat;

    assign accept   = req_valid && req_ready;
    assign rec_we   = accept && (req.func == FUNC_RECORD);
    assign query_go = accept && (req.func == FUNC_QUERY);
    assign last_idx = (idx_reg == fill_reg - CNT_W'(1));

    assign sample_sat = (req.sample_us > FIELD_W'({SAMPLE_BITS{1'b1}})) ?
                        {SAMPLE_BITS{1'b1}} : req.sample_us[SAMPLE_BITS-1:0];

    wts_store u_store (
        .clk   (clk),
        .we    (rec_we),
        .waddr (slot_reg),
        .wdata (sample_sat),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    wts_divsqrt u_divsqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (unit_ctl),
        .operand  (operand),
        .divisor  (fill_reg),
        .stat     (unit_stat),
        .quotient (quotient),
        .root     (root)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_go)
                begin
                    state_next = (fill_reg == '0) ? ST_DONE : ST_SUM_RD;
                end
            end
            ST_SUM_RD:
            begin
                if (last_idx)
                begin
                    state_next = ST_SUM_DRAIN;
                end
            end
            ST_SUM_DRAIN:
            begin
                if (!dv_reg)
                begin
                    state_next = ST_MEAN_START;
                end
            end
            ST_MEAN_START: state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT:
            begin
                if (unit_stat.done)
                begin
                    state_next = (fill_reg < CNT_W'(2)) ? ST_DONE : ST_DEV_RD;
                end
            end
            ST_DEV_RD:
            begin
                if (last_idx)
                begin
                    state_next = ST_DEV_DRAIN;
                end
            end
            ST_DEV_DRAIN:
            begin
                if (!dv_reg && !dfv_reg && !sqv_reg)
                begin
                    state_next = ST_VAR_START;
                end
            end
            ST_VAR_START: state_next = ST_VAR_WAIT;
            ST_VAR_WAIT:
            begin
                if (unit_stat.done)
                begin
                    state_next = ST_ROOT_START;
                end
            end
            ST_ROOT_START: state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT:
            begin
                if (unit_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        req_ready      = 1'b0;
        rd_issue       = 1'b0;
        sum_phase      = 1'b0;
        rsp_load       = 1'b0;
        unit_ctl.start = 1'b0;
        unit_ctl.mode  = MODE_DIV;
        operand        = acc_reg;
        case (state_reg)
            ST_IDLE:       req_ready = 1'b1;
            ST_SUM_RD:
            begin
                rd_issue  = 1'b1;
                sum_phase = 1'b1;
            end
            ST_SUM_DRAIN:  sum_phase = 1'b1;
            ST_MEAN_START: unit_ctl.start = 1'b1;
            ST_DEV_RD:     rd_issue = 1'b1;
            ST_VAR_START:  unit_ctl.start = 1'b1;
            ST_ROOT_START:
            begin
                unit_ctl.start = 1'b1;
                unit_ctl.mode  = MODE_SQRT;
                operand        = SQ_W'(quotient[RAD_W-1:0]);
            end
            ST_DONE:       rsp_load = !rsp_valid_reg || rsp_ready;
            default:       req_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        peak_next      = peak_reg;
        idx_next       = idx_reg;
        dv_next        = rd_issue;
        dfv_next       = dv_reg && !sum_phase;
        sqv_next       = dfv_reg;
        rsp_valid_next = rsp_valid_reg;
        acc_next       = acc_reg;
        mean_next      = mean_reg;
        jit_next       = jit_reg;
        rsp_next       = rsp_reg;

        diff_next = (rd_data >= mean_reg) ? rd_data - mean_reg : mean_reg - rd_data;
        sqr_next  = SQR_W'(diff_reg) * SQR_W'(diff_reg);

        if (rec_we)
        begin
            slot_next = (slot_reg == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + ADDR_W'(1);
            if (fill_reg < CNT_W'(WINDOW_DEPTH))
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
            if (sample_sat > peak_reg)
            begin
                peak_next = sample_sat;
            end
        end

        if (query_go)
        begin
            idx_next  = '0;
            acc_next  = '0;
            mean_next = '0;
            jit_next  = '0;
        end
        else if (rd_issue)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end

        if (dv_reg && sum_phase)
        begin
            acc_next = acc_reg + SQ_W'(rd_data);
        end
        if (sqv_reg)
        begin
            acc_next = acc_reg + SQ_W'(sqr_reg);
        end

        if (state_reg == ST_MEAN_WAIT && unit_stat.done)
        begin
            mean_next = quotient[SAMPLE_BITS-1:0];
            acc_next  = '0;
            idx_next  = '0;
        end
        if (state_reg == ST_ROOT_WAIT && unit_stat.done)
        begin
            jit_next = root;
        end

        if (rsp_load)
        begin
            rsp_valid_next          = 1'b1;
            rsp_next.average_us     = FIELD_W'(mean_reg);
            rsp_next.maximum_us     = FIELD_W'(peak_reg);
            rsp_next.jitter_rms_us  = FIELD_W'(jit_reg);
            rsp_next.stored_samples = OUT_CNT_W'(fill_reg);
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            peak_reg      <= '0;
            idx_reg       <= '0;
            dv_reg        <= 1'b0;
            dfv_reg       <= 1'b0;
            sqv_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            peak_reg      <= peak_next;
            idx_reg       <= idx_next;
            dv_reg        <= dv_next;
            dfv_reg       <= dfv_next;
            sqv_reg       <= sqv_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        diff_reg <= diff_next;
        sqr_reg  <= sqr_next;
        mean_reg <= mean_next;
        jit_reg  <= jit_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `WTS_ASSERT_IMPL(a_fill_range, 1'b1, fill_reg <= CNT_W'(WINDOW_DEPTH), "fill count past depth")
    `WTS_ASSERT_IMPL(a_start_idle, unit_ctl.start, !unit_stat.busy, "unit started while busy")
    `WTS_ASSERT_IMPL(a_rsp_from_done, $rose(rsp_valid_reg), $past(state_reg == ST_DONE), "response outside done")
    `WTS_ASSERT_IMPL(a_fill_on_record, !$stable(fill_reg), $past(rec_we), "fill changed without record")
    `WTS_ASSERT_NEXT(a_peak_mono, 1'b1, peak_reg >= $past(peak_reg), "peak decreased")

endmodule

`default_nettype wire
